FILE: src/tslf_pkg.sv
// ----------------------------------------------------------------------------
// tslf_pkg
// shared types, character codes and bcd helpers for the line formatter
// ----------------------------------------------------------------------------
package tslf_pkg;

    // width of the right-aligned line number field (1 to 10)
    localparam int NUMBER_FIELD_WIDTH = 6;
    localparam int BCD_DIGITS         = 10;
    localparam logic [39:0] LINE_NUMBER_MAX_BCD = 40'h21_4748_3647;

    localparam logic [3:0] FIELD_W = 4'(NUMBER_FIELD_WIDTH);

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4d;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [6:0] CH_DEL    = 7'h7f;

    // configuration register indexes
    typedef enum logic [7:0] {
        REG_NUMBER_NONBLANK  = 8'd0,
        REG_SHOW_ENDS        = 8'd1,
        REG_NUMBER_ALL       = 8'd2,
        REG_SQUEEZE_BLANK    = 8'd3,
        REG_SHOW_TABS        = 8'd4,
        REG_SHOW_NONPRINTING = 8'd5
    } reg_index_t;

    typedef struct packed {
        logic number_nonblank;
        logic show_ends;
        logic number_all;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } mode_t;

    // expanded form of one data byte: up to four bytes, lowest index first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } chr_run_t;

    // number of significant digits, at least one
    function automatic logic [3:0] bcd_ndigits(input logic [39:0] v);
        logic [3:0] nd;
        nd = 4'd1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd0) begin
                nd = 4'(i + 1);
            end
        end
        return nd;
    endfunction

    // saturating bcd increment
    function automatic logic [39:0] bcd_inc(input logic [39:0] v);
        logic [39:0] r;
        logic        carry;
        r     = v;
        carry = 1'b1;
        if (v < LINE_NUMBER_MAX_BCD) begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                if (carry) begin
                    if (v[4*i +: 4] >= 4'd9) begin
                        r[4*i +: 4] = 4'd0;
                    end else begin
                        r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                        carry       = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: src/tslf_char_enc.sv
// ----------------------------------------------------------------------------
// tslf_char_enc
// expands one data byte into its visible form ($, ^I, caret and M- notation)
// ----------------------------------------------------------------------------
module tslf_char_enc (
    input  logic [7:0]        data_byte,
    input  tslf_pkg::mode_t   mode,
    output tslf_pkg::chr_run_t run
);

    logic [6:0] low;

    always_comb begin
        run.bytes = '0;
        run.cnt   = 3'd1;
        low       = data_byte[6:0];
        if (data_byte == tslf_pkg::CH_NL) begin
            if (mode.show_ends) begin
                run.bytes[0] = tslf_pkg::CH_DOLLAR;
                run.bytes[1] = tslf_pkg::CH_NL;
                run.cnt      = 3'd2;
            end else begin
                run.bytes[0] = tslf_pkg::CH_NL;
            end
        end else if (data_byte == tslf_pkg::CH_TAB &&
                     (mode.show_tabs || mode.show_nonprinting)) begin
            if (mode.show_tabs) begin
                run.bytes[0] = tslf_pkg::CH_CARET;
                run.bytes[1] = tslf_pkg::CH_I;
                run.cnt      = 3'd2;
            end else begin
                run.bytes[0] = tslf_pkg::CH_TAB;
            end
        end else if (!mode.show_nonprinting) begin
            run.bytes[0] = data_byte;
        end else if (data_byte[7]) begin
            // high byte: M- then the form of the low seven bits
            run.bytes[0] = tslf_pkg::CH_M;
            run.bytes[1] = tslf_pkg::CH_DASH;
            if (low < 7'd32) begin
                run.bytes[2] = tslf_pkg::CH_CARET;
                run.bytes[3] = {1'b0, low} + 8'd64;
                run.cnt      = 3'd4;
            end else if (low == tslf_pkg::CH_DEL) begin
                run.bytes[2] = tslf_pkg::CH_CARET;
                run.bytes[3] = tslf_pkg::CH_QMARK;
                run.cnt      = 3'd4;
            end else begin
                run.bytes[2] = {1'b0, low};
                run.cnt      = 3'd3;
            end
        end else begin
            if (low < 7'd32) begin
                run.bytes[0] = tslf_pkg::CH_CARET;
                run.bytes[1] = {1'b0, low} + 8'd64;
                run.cnt      = 3'd2;
            end else if (low == tslf_pkg::CH_DEL) begin
                run.bytes[0] = tslf_pkg::CH_CARET;
                run.bytes[1] = tslf_pkg::CH_QMARK;
                run.cnt      = 3'd2;
            end else begin
                run.bytes[0] = data_byte;
            end
        end
    end

endmodule

FILE: src/text_stream_line_formatter_core.sv
// ----------------------------------------------------------------------------
// text_stream_line_formatter_core
// byte stream reformatter: blank line squeezing, line numbering, visible ends,
// tabs and control bytes
// ----------------------------------------------------------------------------
//  channel  direction  ports                          payload
//  s_       in         s_tvalid s_tready s_tdata      data_byte [7:0]
//  m_       out        m_tvalid m_tready m_tdata      out_byte [7:0]
//                      m_tlast                        last_of_run
//  cfg_     in         cfg_valid cfg_ready            cfg_index, cfg_data
//
// each input byte becomes a run of 0 to 15 output bytes, one per cycle on m_
// while m_tready is high, and then a byte is taken every cycle while runs are
// one byte long; a longer run (line number or escape form) holds s_tready
// low until its last transfer. the run register sits between the sides, so
// the next byte is taken in the same cycle as the current run's last transfer.
// reset (aresetn low, synchronous) clears all modes, starts at line 1.
// cfg_ready is always high; writes take effect from the next input byte.
// ----------------------------------------------------------------------------
module text_stream_line_formatter_core (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,    // last_of_run

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic       cfg_data
);

    // mode and line state
    tslf_pkg::mode_t mode_reg;
    logic            at_start_reg, at_start_next;
    logic [1:0]      nl_run_reg, nl_run_next;
    logic [39:0]     line_num_reg, line_num_next;

    // run register: everything needed to serialize one run
    logic                 run_vld_reg, run_vld_next;
    logic                 run_num_en_reg;
    logic [9:0][3:0]      run_digits_reg;
    logic [3:0]           run_nd_reg;
    tslf_pkg::chr_run_t   run_chr_reg;
    logic [3:0]           pos_reg, pos_next;

    tslf_pkg::chr_run_t   chr_run;
    logic                 s_acc, m_acc;
    logic                 is_nl, drop, num_en;

    // output side
    logic [3:0] pad, num_len, run_len, digit_k;
    logic [3:0] chr_off;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tslf_pkg::REG_NUMBER_NONBLANK:  mode_reg.number_nonblank  <= cfg_data;
                tslf_pkg::REG_SHOW_ENDS:        mode_reg.show_ends        <= cfg_data;
                tslf_pkg::REG_NUMBER_ALL:       mode_reg.number_all       <= cfg_data;
                tslf_pkg::REG_SQUEEZE_BLANK:    mode_reg.squeeze_blank    <= cfg_data;
                tslf_pkg::REG_SHOW_TABS:        mode_reg.show_tabs        <= cfg_data;
                tslf_pkg::REG_SHOW_NONPRINTING: mode_reg.show_nonprinting <= cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input side: decide the run for the incoming byte
    // ------------------------------------------------------------------------
    tslf_char_enc u_char_enc (
        .data_byte (s_tdata),
        .mode      (mode_reg),
        .run       (chr_run)
    );

    assign s_tready = !run_vld_reg || (m_tready && m_tlast);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    assign is_nl = (s_tdata == tslf_pkg::CH_NL);
    // third newline in a row at line start is a repeated blank line
    assign drop  = at_start_reg && mode_reg.squeeze_blank && is_nl && (nl_run_reg == 2'd2);
    // nonblank numbering overrides numbering of all lines
    assign num_en = at_start_reg && !drop &&
                    (mode_reg.number_nonblank ? !is_nl : mode_reg.number_all);

    always_comb begin
        at_start_next = at_start_reg;
        nl_run_next   = nl_run_reg;
        line_num_next = line_num_reg;
        run_vld_next  = run_vld_reg;
        pos_next      = pos_reg;
        if (s_acc) begin
            // a squeezed byte yields nothing and leaves the line state alone
            run_vld_next = !drop;
            pos_next     = 4'd0;
            if (!drop) begin
                at_start_next = is_nl;
                if (is_nl) begin
                    nl_run_next = (nl_run_reg == 2'd2) ? 2'd2 : nl_run_reg + 2'd1;
                end else begin
                    nl_run_next = 2'd0;
                end
                if (num_en) begin
                    line_num_next = tslf_pkg::bcd_inc(line_num_reg);
                end
            end
        end else if (m_acc) begin
            if (m_tlast) begin
                run_vld_next = 1'b0;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            nl_run_reg   <= 2'd1;
            line_num_reg <= 40'd1;
            run_vld_reg  <= 1'b0;
            pos_reg      <= 4'd0;
        end else begin
            at_start_reg <= at_start_next;
            nl_run_reg   <= nl_run_next;
            line_num_reg <= line_num_next;
            run_vld_reg  <= run_vld_next;
            pos_reg      <= pos_next;
        end
    end

    // run payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            run_num_en_reg <= num_en;
            run_digits_reg <= line_num_reg;
            run_nd_reg     <= tslf_pkg::bcd_ndigits(line_num_reg);
            run_chr_reg    <= chr_run;
        end
    end

    // ------------------------------------------------------------------------
    // output side: number field (pad, digits, tab) then the expanded byte
    // ------------------------------------------------------------------------
    assign pad     = (tslf_pkg::FIELD_W > run_nd_reg) ? tslf_pkg::FIELD_W - run_nd_reg : 4'd0;
    assign num_len = run_num_en_reg ? pad + run_nd_reg + 4'd1 : 4'd0;
    assign run_len = num_len + {1'b0, run_chr_reg.cnt};
    assign digit_k = run_nd_reg - 4'd1 - (pos_reg - pad);
    assign chr_off = pos_reg - num_len;

    always_comb begin
        if (pos_reg < num_len) begin
            if (pos_reg < pad) begin
                m_tdata = tslf_pkg::CH_SPACE;
            end else if (pos_reg == num_len - 4'd1) begin
                m_tdata = tslf_pkg::CH_TAB;
            end else begin
                m_tdata = {tslf_pkg::CH_ZERO[7:4], run_digits_reg[digit_k]};
            end
        end else begin
            m_tdata = run_chr_reg.bytes[chr_off[1:0]];
        end
    end

    assign m_tvalid = run_vld_reg;
    assign m_tlast  = (pos_reg == run_len - 4'd1);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // serializer position stays inside the run
    a_pos_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_vld_reg |-> (pos_reg < run_len))
        else $error("run position beyond run length");

    // line number saturates
    a_line_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        line_num_reg <= tslf_pkg::LINE_NUMBER_MAX_BCD)
        else $error("line number above saturation value");

    // a newline always leaves the block at line start
    a_nl_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_nl) |=> at_start_reg)
        else $error("newline did not set line start");

    // a squeezed newline changes no line state
    a_drop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && drop) |=> ($stable(line_num_reg) && nl_run_reg == 2'd2 && !run_vld_reg))
        else $error("squeezed newline changed state or made a run");

    // newline run counter never holds the unused code
    a_nl_run: assert property (@(posedge aclk) disable iff (!aresetn)
        nl_run_reg != 2'd3)
        else $error("newline run counter out of range");

endmodule
